FILE: rtl/core/bpka_pkg.sv
// bpka_pkg: shared types and constants for the b-spline parameter and knot block
// no dependencies
`default_nettype none

package bpka_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W     = 6;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int CUM_W     = 32;
    localparam int DEG_W     = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 3;
    localparam int SQ_RAD_W  = 52;
    localparam int SQ_ROOT_W = 26;

    localparam logic [MODE_W-1:0] MODE_CHORD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CENTRIP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b1;

    // value source select for param writes and knot loads
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_ONE  = 2'd1;
    localparam logic [1:0] VS_DIV  = 2'd2;

    // divider operand select
    localparam logic [1:0] DS_CHORD = 2'd0;
    localparam logic [1:0] DS_UNI_P = 2'd1;
    localparam logic [1:0] DS_UNI_K = 2'd2;
    localparam logic [1:0] DS_AVG   = 2'd3;

    typedef struct packed {
        logic             pt_load;
        logic             first;
        logic             diff;
        logic             sqx;
        logic             sqy;
        logic             sq_go;
        logic             sq_sel;
        logic             acc;
        logic             cum_rd;
        logic             pw;
        logic [1:0]       pw_sel;
        logic             div_go;
        logic [1:0]       div_sel;
        logic             sum_clr;
        logic             sum_add;
        logic             par_rd;
        logic             kv_load;
        logic [1:0]       kv_sel;
        logic             out_load;
        logic             out_err;
        logic             out_last;
        logic             out_pvalid;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] n;
        logic [DEG_W-1:0] deg;
    } t_cmd;

    typedef struct packed {
        logic cum_zero;
        logic sq_busy;
        logic div_busy;
        logic out_full;
    } t_sts;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] param_value;
        logic             param_valid;
        logic [VAL_W-1:0] knot_value;
        logic             fit_error;
        logic             last_result;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/core/bpka_pt_if.sv
// bpka_pt_if: point input channel, valid/ready with point payload
// no dependencies
`default_nettype none

interface bpka_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpka_res_if.sv
// bpka_res_if: result output channel, valid/ready with knot payload
// no dependencies
`default_nettype none

interface bpka_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic [16:0] param_value;
    logic        param_valid;
    logic [16:0] knot_value;
    logic        fit_error;
    logic        last_result;

    modport source (output valid, entry_index, param_value, param_valid, knot_value,
                    fit_error, last_result, input ready);
    modport sink   (input valid, entry_index, param_value, param_valid, knot_value,
                    fit_error, last_result, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bspline_param_and_knot_averaging_top.sv
// point items are accepted only while idle, one at a time; each later point takes one root
// pass in chord and uniform mode, two in centripetal; the first point of a set takes none
// run end: point params and then knots are computed one entry at a time, using the divider
// where needed; results leave through a one-entry output register
// synchronous active-low reset clears control state and loads degree 3, chord mode
// stores hold no reset; entries are written before they are read
`default_nettype none

module bspline_param_and_knot_averaging_top #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bpka_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bpka_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    bpka_pt_if.sink                                 i_pt,
    bpka_res_if.source                              o_res
);
    bpka_pkg::t_cmd cmd;
    bpka_pkg::t_sts sts;
    bpka_pkg::t_res res;
    logic           res_valid;
    logic           in_ready;

    bpka_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_pt.valid),
        .i_in_last  (i_pt.last_point),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpka_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pt_x      (i_pt.point_x),
        .i_pt_y      (i_pt.point_y),
        .i_out_ready (o_res.ready),
        .o_sts       (sts),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    assign i_pt.ready        = in_ready;
    assign o_res.valid       = res_valid;
    assign o_res.entry_index = res.entry_index;
    assign o_res.param_value = res.param_value;
    assign o_res.param_valid = res.param_valid;
    assign o_res.knot_value  = res.knot_value;
    assign o_res.fit_error   = res.fit_error;
    assign o_res.last_result = res.last_result;
endmodule

`default_nettype wire

FILE: rtl/core/bpka_sqrt.sv
// bpka_sqrt: bit-serial integer square root, one root bit per cycle
// depends on bpka_pkg
`default_nettype none

module bpka_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bpka_pkg::SQ_RAD_W-1:0]  i_rad,
    output logic      [bpka_pkg::SQ_ROOT_W-1:0] o_root,
    output logic                                o_busy
);
    localparam int RW    = bpka_pkg::SQ_RAD_W;
    localparam int QW    = bpka_pkg::SQ_ROOT_W;
    localparam int REM_W = QW + 4;
    localparam int CNT_W = $clog2(QW + 1);

    logic [RW-1:0]    r_rad;
    logic [REM_W-1:0] r_rem;
    logic [QW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RW-1:RW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[QW-2:0], ge};
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;
endmodule

`default_nettype wire

FILE: rtl/core/bpka_div.sv
// bpka_div: restoring divider, one quotient bit per cycle
// depends on bpka_pkg
`default_nettype none

module bpka_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [bpka_pkg::CUM_W+FRAC_BITS:0]     i_num,
    input  wire logic [bpka_pkg::CUM_W-1:0]             i_den,
    output logic      [FRAC_BITS:0]                     o_q,
    output logic                                        o_busy
);
    localparam int QW    = FRAC_BITS + 1;
    localparam int DW    = bpka_pkg::CUM_W;
    localparam int DNW   = DW + QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DW:0] t;
    logic        ge;

    assign t  = {r_rem, r_lo[QW-1]};
    assign ge = t >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DNW-1:QW];
            r_lo  <= i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? DW'(t - {1'b0, i_den}) : DW'(t);
            r_lo  <= {r_lo[QW-2:0], ge};
        end
    end

    assign o_q    = r_lo;
    assign o_busy = r_busy;
endmodule

`default_nettype wire

FILE: rtl/core/bpka_dp.sv
// bpka_dp: datapath with length, parameter and knot arithmetic and both stores
// depends on bpka_pkg, bpka_sqrt, bpka_div
`default_nettype none

module bpka_dp #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bpka_pkg::t_cmd i_cmd,
    input  wire logic [15:0]    i_pt_x,
    input  wire logic [15:0]    i_pt_y,
    input  wire logic           i_out_ready,
    output bpka_pkg::t_sts      o_sts,
    output bpka_pkg::t_res      o_res,
    output logic                o_res_valid
);
    localparam int FRAC_BITS = bpka_pkg::FRAC_BITS;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CB   = bpka_pkg::COORD_BITS;
    localparam int LF   = 24 - CB;
    localparam int VW   = FRAC_BITS + 1;
    localparam int CW   = bpka_pkg::CUM_W;
    localparam int DNW  = CW + VW;
    localparam int AXW  = CB + 1;
    localparam int D2W  = 2 * CB + 3;
    localparam int SW   = VW + 3;
    localparam int RW   = bpka_pkg::SQ_RAD_W;
    localparam int IW   = bpka_pkg::IDX_W;
    localparam logic [VW-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};

    logic [CB-1:0]  r_cx, r_cy, r_px, r_py;
    logic [AXW-1:0] r_ax, r_ay;
    logic [D2W-1:0] r_d2;
    logic [CW-1:0]  r_cum_last;
    logic [CW-1:0]  r_cum_rd;
    logic [VW-1:0]  r_par_rd;
    logic [SW-1:0]  r_sum;
    logic [VW-1:0]  r_kv;
    bpka_pkg::t_res r_res;
    logic           r_oval;

    logic [CW-1:0]  cum_mem [MAX_POINTS];
    logic [VW-1:0]  par_mem [MAX_POINTS];

    logic signed [AXW-1:0] dx, dy;
    logic [RW-1:0]         sq_rad;
    logic [bpka_pkg::SQ_ROOT_W-1:0] root;
    logic                  sq_busy;
    logic [CW-1:0]         cum_sum;
    logic [DNW-1:0]        div_num;
    logic [CW-1:0]         div_den;
    logic [VW-1:0]         div_q;
    logic                  div_busy;
    logic [IW-1:0]         n_m1, n_md, i_md;

    assign dx = $signed({r_cx[CB-1], r_cx}) - $signed({r_px[CB-1], r_px});
    assign dy = $signed({r_cy[CB-1], r_cy}) - $signed({r_py[CB-1], r_py});

    assign sq_rad = i_cmd.sq_sel ? (RW'(root) << LF) : (RW'(r_d2) << (2 * LF));
    assign cum_sum = r_cum_last + CW'(root);

    bpka_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_go),
        .i_rad   (sq_rad),
        .o_root  (root),
        .o_busy  (sq_busy)
    );

    assign n_m1 = i_cmd.n - 1'b1;
    assign n_md = i_cmd.n - IW'(i_cmd.deg);
    assign i_md = i_cmd.idx - IW'(i_cmd.deg);

    always_comb begin
        case (i_cmd.div_sel)
            bpka_pkg::DS_CHORD: begin
                div_num = (DNW'(r_cum_rd) << FRAC_BITS) + DNW'(r_cum_last >> 1);
                div_den = r_cum_last;
            end
            bpka_pkg::DS_UNI_P: begin
                div_num = (DNW'(i_cmd.idx) << FRAC_BITS) + DNW'(n_m1 >> 1);
                div_den = CW'(n_m1);
            end
            bpka_pkg::DS_UNI_K: begin
                div_num = (DNW'(i_md) << FRAC_BITS) + DNW'(n_md >> 1);
                div_den = CW'(n_md);
            end
            default: begin
                div_num = DNW'(r_sum) + DNW'(i_cmd.deg >> 1);
                div_den = CW'(i_cmd.deg);
            end
        endcase
    end

    bpka_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_q     (div_q),
        .o_busy  (div_busy)
    );

    // point and length registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_load) begin
            r_cx <= CB'(i_pt_x);
            r_cy <= CB'(i_pt_y);
        end
        if (i_cmd.first) begin
            r_px       <= r_cx;
            r_py       <= r_cy;
            r_cum_last <= '0;
        end
        if (i_cmd.diff) begin
            r_ax <= dx[CB] ? AXW'(-dx) : AXW'(dx);
            r_ay <= dy[CB] ? AXW'(-dy) : AXW'(dy);
            r_px <= r_cx;
            r_py <= r_cy;
        end
        if (i_cmd.sqx) begin
            r_d2 <= D2W'(r_ax * r_ax);
        end
        if (i_cmd.sqy) begin
            r_d2 <= r_d2 + D2W'(r_ay * r_ay);
        end
        if (i_cmd.acc) begin
            r_cum_last <= cum_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            cum_mem[AW'(0)] <= '0;
        end else if (i_cmd.acc) begin
            cum_mem[i_cmd.idx[AW-1:0]] <= cum_sum;
        end
        if (i_cmd.cum_rd) begin
            r_cum_rd <= cum_mem[i_cmd.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pw) begin
            case (i_cmd.pw_sel)
                bpka_pkg::VS_ZERO: par_mem[i_cmd.idx[AW-1:0]] <= '0;
                bpka_pkg::VS_ONE:  par_mem[i_cmd.idx[AW-1:0]] <= ONE_V;
                default:           par_mem[i_cmd.idx[AW-1:0]] <= div_q;
            endcase
        end
        if (i_cmd.par_rd) begin
            r_par_rd <= par_mem[i_cmd.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + SW'(r_par_rd);
        end
        if (i_cmd.kv_load) begin
            case (i_cmd.kv_sel)
                bpka_pkg::VS_ZERO: r_kv <= '0;
                bpka_pkg::VS_ONE:  r_kv <= ONE_V;
                default:           r_kv <= div_q;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_oval <= 1'b1;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res.entry_index <= i_cmd.idx;
            r_res.param_value <= i_cmd.out_pvalid ? bpka_pkg::VAL_W'(r_par_rd) : '0;
            r_res.param_valid <= i_cmd.out_pvalid;
            r_res.knot_value  <= i_cmd.out_err ? '0 : bpka_pkg::VAL_W'(r_kv);
            r_res.fit_error   <= i_cmd.out_err;
            r_res.last_result <= i_cmd.out_last;
        end
    end

    assign o_sts.cum_zero = (r_cum_last == '0);
    assign o_sts.sq_busy  = sq_busy;
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_full = r_oval;
    assign o_res          = r_res;
    assign o_res_valid    = r_oval;
endmodule

`default_nettype wire

FILE: rtl/core/bpka_ctrl.sv
// bpka_ctrl: controller state machine, point count and configuration registers
// depends on bpka_pkg
`default_nettype none

module bpka_ctrl #(
    parameter int MAX_POINTS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bpka_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bpka_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_last,
    output logic                                    o_in_ready,
    input  wire bpka_pkg::t_sts                     i_sts,
    output bpka_pkg::t_cmd                          o_cmd
);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int IW = bpka_pkg::IDX_W;
    localparam int DW = bpka_pkg::DEG_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PT   = 5'd1;
    localparam logic [4:0] S_SQX  = 5'd2;
    localparam logic [4:0] S_SQY  = 5'd3;
    localparam logic [4:0] S_RT1  = 5'd4;
    localparam logic [4:0] S_RT1W = 5'd5;
    localparam logic [4:0] S_RT2  = 5'd6;
    localparam logic [4:0] S_RT2W = 5'd7;
    localparam logic [4:0] S_ACC  = 5'd8;
    localparam logic [4:0] S_END  = 5'd9;
    localparam logic [4:0] S_ERRO = 5'd10;
    localparam logic [4:0] S_P0   = 5'd11;
    localparam logic [4:0] S_P1   = 5'd12;
    localparam logic [4:0] S_P2   = 5'd13;
    localparam logic [4:0] S_K0   = 5'd14;
    localparam logic [4:0] S_KS   = 5'd15;
    localparam logic [4:0] S_KA   = 5'd16;
    localparam logic [4:0] S_KD   = 5'd17;
    localparam logic [4:0] S_KW   = 5'd18;
    localparam logic [4:0] S_KPV  = 5'd19;
    localparam logic [4:0] S_KO   = 5'd20;

    logic [4:0]                    r_state, n_state;
    logic [NW-1:0]                 r_count, n_count;
    logic                          r_ovf, n_ovf;
    logic                          r_last, n_last;
    logic [IW-1:0]                 r_i, n_i;
    logic [IW-1:0]                 r_k, n_k;
    logic [IW-1:0]                 r_n, n_n;
    logic [DW-1:0]                 r_deg, n_deg;
    logic                          r_uni, n_uni;
    logic [DW-1:0]                 r_cfg_deg;
    logic [bpka_pkg::MODE_W-1:0]   r_cfg_mode;

    logic [DW-1:0] deg_eff;
    logic          uni_now;
    logic          err;
    logic          accept;

    assign deg_eff = (r_cfg_deg == '0) ? DW'(1) : r_cfg_deg;
    assign uni_now = (r_cfg_mode != bpka_pkg::MODE_CHORD)
                   && (r_cfg_mode != bpka_pkg::MODE_CENTRIP);
    assign err = r_ovf || (r_count < NW'(2))
              || ((NW + 1)'(r_count) < ((NW + 1)'(deg_eff) + 1'b1))
              || (!uni_now && i_sts.cum_zero);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_deg  <= DW'(3);
            r_cfg_mode <= bpka_pkg::MODE_CHORD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpka_pkg::CFG_DEGREE: r_cfg_deg  <= i_cfg_data[DW-1:0];
                bpka_pkg::CFG_MODE:   r_cfg_mode <= i_cfg_data[bpka_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_last  = r_last;
        n_i     = r_i;
        n_k     = r_k;
        n_n     = r_n;
        n_deg   = r_deg;
        n_uni   = r_uni;
        o_cmd      = '0;
        o_cmd.idx  = r_i;
        o_cmd.addr = r_i;
        o_cmd.n    = r_n;
        o_cmd.deg  = r_deg;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.pt_load = 1'b1;
                    n_last  = i_in_last;
                    n_state = S_PT;
                end
            end
            S_PT: begin
                if (r_count == NW'(MAX_POINTS)) begin
                    n_ovf   = 1'b1;
                    n_state = S_END;
                end else if (r_count == '0) begin
                    o_cmd.first = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_END;
                end else begin
                    o_cmd.diff = 1'b1;
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.sqx = 1'b1;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.sqy = 1'b1;
                n_state = S_RT1;
            end
            S_RT1: begin
                o_cmd.sq_go = 1'b1;
                n_state = S_RT1W;
            end
            S_RT1W: begin
                if (!i_sts.sq_busy) begin
                    n_state = (r_cfg_mode == bpka_pkg::MODE_CENTRIP) ? S_RT2 : S_ACC;
                end
            end
            S_RT2: begin
                o_cmd.sq_go  = 1'b1;
                o_cmd.sq_sel = 1'b1;
                n_state = S_RT2W;
            end
            S_RT2W: begin
                if (!i_sts.sq_busy) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                o_cmd.idx = IW'(r_count);
                n_count = r_count + 1'b1;
                n_state = S_END;
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_n   = IW'(r_count);
                    n_deg = deg_eff;
                    n_uni = uni_now;
                    n_i   = '0;
                    n_state = err ? S_ERRO : S_P0;
                end
            end
            S_ERRO: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.idx      = '0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_P0: begin
                o_cmd.cum_rd = 1'b1;
                if (r_uni || ((r_i != '0) && (r_i != r_n - 1'b1))) begin
                    n_state = S_P1;
                end else begin
                    o_cmd.pw     = 1'b1;
                    o_cmd.pw_sel = (r_i == '0) ? bpka_pkg::VS_ZERO : bpka_pkg::VS_ONE;
                    if (r_i == r_n - 1'b1) begin
                        n_i = '0;
                        n_state = S_K0;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_P0;
                    end
                end
            end
            S_P1: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = r_uni ? bpka_pkg::DS_UNI_P : bpka_pkg::DS_CHORD;
                n_state = S_P2;
            end
            S_P2: begin
                o_cmd.div_sel = r_uni ? bpka_pkg::DS_UNI_P : bpka_pkg::DS_CHORD;
                if (!i_sts.div_busy) begin
                    o_cmd.pw     = 1'b1;
                    o_cmd.pw_sel = bpka_pkg::VS_DIV;
                    if (r_i == r_n - 1'b1) begin
                        n_i = '0;
                        n_state = S_K0;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_P0;
                    end
                end
            end
            S_K0: begin
                if (r_i <= IW'(r_deg)) begin
                    o_cmd.kv_load = 1'b1;
                    o_cmd.kv_sel  = bpka_pkg::VS_ZERO;
                    n_state = S_KPV;
                end else if (r_i >= r_n) begin
                    o_cmd.kv_load = 1'b1;
                    o_cmd.kv_sel  = bpka_pkg::VS_ONE;
                    n_state = S_KPV;
                end else if (r_uni) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = bpka_pkg::DS_UNI_K;
                    n_state = S_KW;
                end else begin
                    o_cmd.sum_clr = 1'b1;
                    n_k = r_i - IW'(r_deg);
                    n_state = S_KS;
                end
            end
            S_KS: begin
                o_cmd.par_rd = 1'b1;
                o_cmd.addr   = r_k;
                n_k = r_k + 1'b1;
                n_state = S_KA;
            end
            S_KA: begin
                o_cmd.sum_add = 1'b1;
                n_state = (r_k == r_i) ? S_KD : S_KS;
            end
            S_KD: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = bpka_pkg::DS_AVG;
                n_state = S_KW;
            end
            S_KW: begin
                o_cmd.div_sel = r_uni ? bpka_pkg::DS_UNI_K : bpka_pkg::DS_AVG;
                if (!i_sts.div_busy) begin
                    o_cmd.kv_load = 1'b1;
                    o_cmd.kv_sel  = bpka_pkg::VS_DIV;
                    n_state = S_KPV;
                end
            end
            S_KPV: begin
                o_cmd.par_rd = (r_i < r_n);
                n_state = S_KO;
            end
            S_KO: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_pvalid = (r_i < r_n);
                    o_cmd.out_last   = (r_i == r_n + IW'(r_deg));
                    if (r_i == r_n + IW'(r_deg)) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_K0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_i     <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_deg   <= '0;
            r_uni   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
            r_i     <= n_i;
            r_k     <= n_k;
            r_n     <= n_n;
            r_deg   <= n_deg;
            r_uni   <= n_uni;
        end
    end
endmodule

`default_nettype wire
